/* sv/polygon_obstacle_point_test_top_defines.svh */
// assertion macros for the polygon obstacle point test block
// used by polygon_obstacle_point_test_top; expects aclk and aresetn in scope
`ifndef POLYGON_OBSTACLE_POINT_TEST_TOP_DEFINES_SVH
`define POLYGON_OBSTACLE_POINT_TEST_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define POT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define POT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pot_pkg.sv */
// shared types, constants and arithmetic helpers of the polygon obstacle point test
// no dependencies
`default_nettype none

package pot_pkg;

    localparam int COORD_BITS       = 16;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int POLY_MIN_VERTS   = 3;
    localparam int RAY_END_X_RST    = 16000;
    localparam int EDGE_TOL_RST     = 0;
    localparam int TOL_BITS         = 8;
    localparam int COLLINEAR_LIM    = 256;

    localparam int S_DATA_W   = 2 * COORD_BITS;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_RAY_END_X = 1'b0;
    localparam logic REG_EDGE_TOL  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic signed [2*COORD_BITS+1:0] prod_t;
    typedef logic signed [2*COORD_BITS+2:0] cross_t;
    typedef logic signed [COORD_BITS+1:0] wide_t;
    typedef logic [TOL_BITS-1:0]          tol_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } pt_t;

    typedef struct packed {
        logic mark;
        pt_t  pt;
    } vtx_t;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_POS = 2'd1,
        ORI_NEG = 2'd2
    } orient_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic last;
        logic poly_ok;
    } edge_tag_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic poly_ok;
        logic crossed;
        logic on_line;
        logic seg_p;
    } edge_res_t;

    // orientation of a cross product given as its two partial products
    function automatic orient_t orient_of(prod_t pa, prod_t pb);
        cross_t v;
        v = cross_t'(pa) - cross_t'(pb);
        if (v < cross_t'(COLLINEAR_LIM) && v > -cross_t'(COLLINEAR_LIM)) begin
            return ORI_COL;
        end else if (v > 0) begin
            return ORI_POS;
        end else begin
            return ORI_NEG;
        end
    endfunction

    // q inside the box of p and r, widened by the tolerance
    function automatic logic on_seg(pt_t p, pt_t q, pt_t r, tol_t t);
        wide_t px, py, qx, qy, rx, ry, tw;
        wide_t mxx, mnx, mxy, mny;
        px  = wide_t'(p.x);
        py  = wide_t'(p.y);
        qx  = wide_t'(q.x);
        qy  = wide_t'(q.y);
        rx  = wide_t'(r.x);
        ry  = wide_t'(r.y);
        tw  = wide_t'({1'b0, t});
        mxx = (px > rx) ? px : rx;
        mnx = (px < rx) ? px : rx;
        mxy = (py > ry) ? py : ry;
        mny = (py < ry) ? py : ry;
        return (qx - tw <= mxx) && (qx + tw >= mnx) &&
               (qy - tw <= mxy) && (qy + tw >= mny);
    endfunction

endpackage

`default_nettype wire

/* sv/pot_vcell.sv */
// one vertex cell of the rotating vertex ring
// depends on pot_pkg
`default_nettype none

module pot_vcell import pot_pkg::*; (
    input  wire logic aclk,
    input  wire logic shift_en,
    input  vtx_t      d_in,
    output vtx_t      q_out
);

    vtx_t vtx_reg;

    // payload only, contents undefined until an append reaches this cell
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            vtx_reg <= d_in;
        end
    end

    assign q_out = vtx_reg;

endmodule

`default_nettype wire

/* sv/pot_edge_eval.sv */
// pipelined edge test: orientation products, crossing and on-segment flags
// depends on pot_pkg
`default_nettype none

module pot_edge_eval import pot_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  edge_tag_t  in_tag,
    input  pt_t        va,
    input  pt_t        vb,
    input  pt_t        qpt,
    input  pt_t        far_pt,
    input  tol_t       tol,
    output edge_res_t  res,
    output logic       busy
);

    localparam int N_ORI = 5;
    // orientation slots
    localparam int O_EDGE_P   = 0;
    localparam int O_EDGE_FAR = 1;
    localparam int O_RAY_A    = 2;
    localparam int O_RAY_B    = 3;
    localparam int O_ON_LINE  = 4;

    pt_t op_p [N_ORI];
    pt_t op_q [N_ORI];
    pt_t op_r [N_ORI];

    // stage 1: coordinate differences
    logic      v1_reg;
    edge_tag_t tag1_reg;
    diff_t     a_reg [N_ORI];
    diff_t     b_reg [N_ORI];
    diff_t     c_reg [N_ORI];
    diff_t     d_reg [N_ORI];
    pt_t       va1_reg, vb1_reg, q1_reg, far1_reg;
    tol_t      tol1_reg;

    // stage 2: products and box tests
    logic       v2_reg;
    edge_tag_t  tag2_reg;
    prod_t      pa_reg [N_ORI];
    prod_t      pb_reg [N_ORI];
    logic [3:0] seg_reg;

    edge_res_t res_reg;
    edge_res_t res_next;
    orient_t   ori [N_ORI];

    always_comb begin
        op_p[O_EDGE_P]   = va;   op_q[O_EDGE_P]   = vb;     op_r[O_EDGE_P]   = qpt;
        op_p[O_EDGE_FAR] = va;   op_q[O_EDGE_FAR] = vb;     op_r[O_EDGE_FAR] = far_pt;
        op_p[O_RAY_A]    = qpt;  op_q[O_RAY_A]    = far_pt; op_r[O_RAY_A]    = va;
        op_p[O_RAY_B]    = qpt;  op_q[O_RAY_B]    = far_pt; op_r[O_RAY_B]    = vb;
        op_p[O_ON_LINE]  = va;   op_q[O_ON_LINE]  = qpt;    op_r[O_ON_LINE]  = vb;
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N_ORI; k++) begin
            a_reg[k] <= diff_t'(op_q[k].y) - diff_t'(op_p[k].y);
            b_reg[k] <= diff_t'(op_r[k].x) - diff_t'(op_q[k].x);
            c_reg[k] <= diff_t'(op_q[k].x) - diff_t'(op_p[k].x);
            d_reg[k] <= diff_t'(op_r[k].y) - diff_t'(op_q[k].y);
        end
        tag1_reg <= in_tag;
        va1_reg  <= va;
        vb1_reg  <= vb;
        q1_reg   <= qpt;
        far1_reg <= far_pt;
        tol1_reg <= tol;

        for (int k = 0; k < N_ORI; k++) begin
            pa_reg[k] <= a_reg[k] * b_reg[k];
            pb_reg[k] <= c_reg[k] * d_reg[k];
        end
        seg_reg[0] <= on_seg(va1_reg, q1_reg, vb1_reg, tol1_reg);
        seg_reg[1] <= on_seg(va1_reg, far1_reg, vb1_reg, tol1_reg);
        seg_reg[2] <= on_seg(q1_reg, va1_reg, far1_reg, tol1_reg);
        seg_reg[3] <= on_seg(q1_reg, vb1_reg, far1_reg, tol1_reg);
        tag2_reg   <= tag1_reg;
    end

    // stage 3: classify and combine
    always_comb begin
        for (int k = 0; k < N_ORI; k++) begin
            ori[k] = orient_of(pa_reg[k], pb_reg[k]);
        end
        res_next.valid   = v2_reg;
        res_next.last    = tag2_reg.last;
        res_next.poly_ok = tag2_reg.poly_ok;
        res_next.crossed = ((ori[O_EDGE_P] != ori[O_EDGE_FAR]) &&
                            (ori[O_RAY_A] != ori[O_RAY_B])) ||
                           ((ori[O_EDGE_P] == ORI_COL) && seg_reg[0]) ||
                           ((ori[O_EDGE_FAR] == ORI_COL) && seg_reg[1]) ||
                           ((ori[O_RAY_A] == ORI_COL) && seg_reg[2]) ||
                           ((ori[O_RAY_B] == ORI_COL) && seg_reg[3]);
        res_next.on_line = (ori[O_ON_LINE] == ORI_COL);
        res_next.seg_p   = seg_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            res_reg <= '0;
        end else begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            res_reg <= res_next;
        end
    end

    assign res  = res_reg;
    assign busy = v1_reg | v2_reg | res_reg.valid;

endmodule

`default_nettype wire

/* sv/polygon_obstacle_point_test_top.sv */
// top level of the polygon obstacle point test: vertex ring, sequencer, config port
// depends on pot_pkg, pot_vcell, pot_edge_eval and the assertion macro header
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid/s_tready      tdata {y_coord, x_coord}, tuser mode, tlast closes
//  m_*       out  m_tvalid/m_tready      tdata {overflow, point_free}, zero filled to 8 bits
//  apb       in   psel/penable/pready    ray_end_x at 0x0, edge_tolerance at 0x4
//
//  clear and append act on the word at acceptance; the result is then moved into the
//  output register from ST_FINISH once that register is free
//  a query rotates the vertex ring past a single pipelined edge evaluator, one cell
//  per cycle except where it holds at each polygon end for that polygon's closing edge
//  reset is synchronous on aresetn low; the vertex ring itself is not cleared
//  a new word is taken while the previous result waits in the output register;
//  the block only waits for m_tready when it has its next result ready
`default_nettype none

`include "polygon_obstacle_point_test_top_defines.svh"

module polygon_obstacle_point_test_top import pot_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [15:0] x_coord, [31:16] y_coord
    input  wire logic [S_USER_W-1:0]   s_tuser,   // [1:0] mode
    input  wire logic                  s_tlast,   // closes_polygon

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [0] point_free, [1] overflow, rest zero

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int STEP_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W  = CNT_W + 1;

    // ---------------- configuration registers ----------------
    coord_t ray_reg;
    tol_t   tol_reg;
    logic   cfg_wr;
    logic   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_reg <= coord_t'(RAY_END_X_RST);
            tol_reg <= tol_t'(EDGE_TOL_RST);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RAY_END_X: ray_reg <= pwdata[COORD_BITS-1:0];
                REG_EDGE_TOL:  tol_reg <= pwdata[TOL_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RAY_END_X: prdata = APB_DATA_W'({1'b0, ray_reg});
            REG_EDGE_TOL:  prdata = APB_DATA_W'(tol_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- vertex ring ----------------
    // appends shift the ring toward cell 0 and enter at the tail, so the stored
    // vertices sit in order in the top cells; a query rotates the ring once fully
    vtx_t cell_q [MAX_VERTICES];
    vtx_t tail_in;
    vtx_t head;
    vtx_t new_vtx;
    logic shift_en;
    logic append_shift;

    assign head      = cell_q[0];
    assign new_vtx.mark = s_tlast;
    assign new_vtx.pt.x = s_tdata[COORD_BITS-1:0];
    assign new_vtx.pt.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign tail_in   = append_shift ? new_vtx : head;

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
        vtx_t d_in;
        if (i == MAX_VERTICES - 1) begin : g_tail
            assign d_in = tail_in;
        end else begin : g_body
            assign d_in = cell_q[i+1];
        end
        pot_vcell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q_out    (cell_q[i])
        );
    end

    // ---------------- edge evaluator ----------------
    logic      e_valid;
    edge_tag_t e_tag;
    pt_t       e_va;
    pt_t       e_vb;
    pt_t       far_pt;
    pt_t       qpt_reg;
    edge_res_t e_res;
    logic      e_busy;

    pot_edge_eval u_edge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (e_valid),
        .in_tag   (e_tag),
        .va       (e_va),
        .vb       (e_vb),
        .qpt      (qpt_reg),
        .far_pt   (far_pt),
        .tol      (tol_reg),
        .res      (e_res),
        .busy     (e_busy)
    );

    // ---------------- sequencer ----------------
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]       n_reg, n_next;          // vertices seen in polygon, stops at 3
    logic             pend_reg, pend_next;    // closing edge owed for head
    pt_t              first_reg, first_next;
    pt_t              prev_reg, prev_next;
    pt_t              qpt_next;
    logic             free_reg, free_next;
    logic             ovf_reg, ovf_next;
    logic             par_reg, par_next;      // crossing parity of current polygon
    logic             dec_reg, dec_next;      // polygon settled by a collinear crossing
    logic             dval_reg, dval_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_data_reg, m_data_next;

    logic head_valid;
    logic last_step;
    logic rotate;
    logic poly_in;

    assign far_pt.x   = ray_reg;
    assign far_pt.y   = qpt_reg.y;
    assign head_valid = (SUM_W'(step_reg) + SUM_W'(count_reg)) >= SUM_W'(MAX_VERTICES);
    assign last_step  = (step_reg == STEP_W'(MAX_VERTICES - 1));
    assign s_tready   = (state_reg == ST_IDLE);
    assign shift_en   = append_shift | rotate;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        n_next       = n_reg;
        pend_next    = pend_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        qpt_next     = qpt_reg;
        free_next    = free_reg;
        ovf_next     = ovf_reg;
        par_next     = par_reg;
        dec_next     = dec_reg;
        dval_next    = dval_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        append_shift = 1'b0;
        rotate       = 1'b0;
        e_valid      = 1'b0;
        e_tag        = '0;
        e_va         = prev_reg;
        e_vb         = head.pt;
        poly_in      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // fold finished edge results into the polygon state
        if (e_res.valid) begin
            if (!dec_reg && e_res.crossed) begin
                if (e_res.on_line) begin
                    dec_next  = 1'b1;
                    dval_next = e_res.seg_p;
                end else begin
                    par_next = ~par_reg;
                end
            end
            if (e_res.last) begin
                poly_in = dec_next ? dval_next : par_next;
                if (e_res.poly_ok && poly_in) begin
                    free_next = 1'b0;
                end
                par_next = 1'b0;
                dec_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    free_next  = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_FINISH;
                    case (mode_t'(s_tuser))
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_APPEND: begin
                            if (count_reg >= CNT_W'(MAX_VERTICES)) begin
                                ovf_next = 1'b1;
                            end else begin
                                append_shift = 1'b1;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            qpt_next   = new_vtx.pt;
                            step_next  = '0;
                            n_next     = '0;
                            pend_next  = 1'b0;
                            par_next   = 1'b0;
                            dec_next   = 1'b0;
                            state_next = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RUN: begin
                if (pend_reg) begin
                    // closing edge from the marked vertex back to the polygon's first
                    e_valid       = 1'b1;
                    e_tag.last    = 1'b1;
                    e_tag.poly_ok = (n_reg == 2'(POLY_MIN_VERTS));
                    e_va          = head.pt;
                    e_vb          = first_reg;
                    n_next        = '0;
                    pend_next     = 1'b0;
                    rotate        = 1'b1;
                end else if (head_valid) begin
                    e_valid    = (n_reg != '0);
                    e_va       = prev_reg;
                    e_vb       = head.pt;
                    prev_next  = head.pt;
                    if (n_reg == '0) begin
                        first_next = head.pt;
                    end
                    if (n_reg != 2'(POLY_MIN_VERTS)) begin
                        n_next = n_reg + 1'b1;
                    end
                    if (head.mark) begin
                        pend_next = 1'b1;
                    end else begin
                        rotate = 1'b1;
                    end
                end else begin
                    rotate = 1'b1;
                end
                if (rotate) begin
                    if (last_step) begin
                        step_next  = '0;
                        state_next = ST_DRAIN;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            ST_DRAIN: begin
                if (!e_busy) begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ovf_reg, free_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        n_reg      <= n_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        qpt_reg    <= qpt_next;
        free_reg   <= free_next;
        ovf_reg    <= ovf_next;
        par_reg    <= par_next;
        dec_reg    <= dec_next;
        dval_reg   <= dval_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    // ---------------- checks ----------------
    `POT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_VERTICES), "vertex count past capacity")
    `POT_ASSERT_NOW(a_pend_marked, pend_reg, head.mark && state_reg == ST_RUN, "closing edge owed for unmarked head")
    `POT_ASSERT_NEXT(a_ring_wrap, state_reg == ST_RUN && state_next == ST_DRAIN, step_reg == '0, "ring rotation did not wrap")
    `POT_ASSERT_NOW(a_drained, state_reg == ST_FINISH, !e_busy, "result taken while edges in flight")

endmodule

`default_nettype wire
